/* sv/iat_pkg.sv */
// Shared types, widths and codes for the integrated autocorrelation time core.
package iat_pkg;

  localparam int unsigned DataW             = 32;
  localparam int unsigned GW                = 64;
  localparam int unsigned WideW             = 128;
  localparam int unsigned MulBW             = 64;
  localparam int unsigned StatW             = 2;
  localparam int unsigned MaxSamplesDefault = 4096;

  typedef enum logic [StatW-1:0] {
    StatOk    = 2'd0,
    StatShort = 2'd1,
    StatDegen = 2'd2
  } stat_e;

  typedef enum logic [3:0] {
    OpNone = 4'd0,
    OpMean = 4'd1,
    OpMp   = 4'd2,
    OpSs   = 4'd3,
    OpMm   = 4'd4,
    OpG    = 4'd5,
    OpTt   = 4'd6,
    OpNg   = 4'd7,
    OpErr  = 4'd8,
    OpSqrt = 4'd9
  } op_e;

  typedef struct packed {
    logic  load;
    logic  eval_start;
    logic  sweep_clr;
    logic  sweep_run;
    logic  lag_upd;
    op_e   op;
    logic  stat_we;
    stat_e stat;
    logic  publish;
  } cmd_t;

  typedef struct packed {
    logic op_done;
    logic sweep_done;
    logic k_zero;
    logic n_lt2;
    logic neg;
    logic g0_zero;
    logic k_end;
    logic ng_lt;
    logic q_hi_nz;
    logic out_busy;
  } sts_t;

endpackage

/* sv/iat_if.sv */
// Valid/ready channel interfaces for sample beats and result beats.
interface iat_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [iat_pkg::DataW-1:0] sample;
  logic                             last;
  modport source (output valid, sample, last, input ready);
  modport sink   (input valid, sample, last, output ready);
endinterface

interface iat_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [iat_pkg::DataW-1:0] mean;
  logic        [iat_pkg::DataW-1:0] error;
  logic        [iat_pkg::DataW-1:0] tau_twice;
  logic        [iat_pkg::StatW-1:0] status;
  modport source (output valid, mean, error, tau_twice, status, input ready);
  modport sink   (input valid, mean, error, tau_twice, status, output ready);
endinterface

/* sv/integrated_autocorrelation_time_core.sv */
// Throughput: sample beats are taken one per cycle while idle; a beat marked last stalls input.
// After the last beat, each lag k in turn is swept over its n-k sample pairs and evaluated
// in the serial 64-step multiplier and 128-step divider (the mean is divided after lag 0),
// up to the first negative lag or the last; a tail then derives tau, status and the error.
// Reset clears the sample count, the controller and the result valid; memory is not cleared.
module integrated_autocorrelation_time_core #(
  parameter int unsigned MAX_SAMPLES = iat_pkg::MaxSamplesDefault
) (
  input logic       clk_i,
  input logic       rst_ni,
  iat_in_if.sink    in_i,
  iat_out_if.source res_o
);

  // Command and status bundles between the sequencer and the datapath.
  iat_pkg::cmd_t cmd;
  iat_pkg::sts_t sts;
  logic          in_ready;
  logic          in_acc;

  // A sample beat lands when the sequencer is idle; the last beat of a series
  // also launches the evaluation.
  assign in_i.ready = in_ready;
  assign in_acc     = in_i.valid && in_ready;

  iat_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_acc_i   (in_acc),
    .last_i     (in_i.last),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (in_ready)
  );

  // The datapath holds the result in an output register, so a new series can
  // be loaded while the previous result beat still waits for its consumer.
  iat_dp #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i       (cmd),
    .sample_i    (in_i.sample),
    .out_ready_i (res_o.ready),
    .sts_o       (sts),
    .out_valid_o (res_o.valid),
    .mean_o      (res_o.mean),
    .error_o     (res_o.error),
    .tau_twice_o (res_o.tau_twice),
    .status_o    (res_o.status)
  );

endmodule

/* sv/iat_mul.sv */
// Radix-2 shift-add multiplier, one multiplier bit per cycle.
module iat_mul #(
  parameter int unsigned AW = iat_pkg::WideW,
  parameter int unsigned BW = iat_pkg::MulBW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [AW-1:0] a_i,
  input  logic [BW-1:0] b_i,
  output logic          done_o,
  output logic [AW-1:0] p_o
);
  localparam int unsigned CntW = $clog2(BW);

  logic [AW-1:0]   a_q, acc_q;
  logic [BW-1:0]   b_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CntW'(BW - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(BW - 1)) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      if (b_q[0]) acc_q <= acc_q + a_q;
      a_q <= {a_q[AW-2:0], 1'b0};
      b_q <= {1'b0, b_q[BW-1:1]};
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

/* sv/iat_div.sv */
// Restoring divider, one quotient bit per cycle.
module iat_div #(
  parameter int unsigned W = iat_pkg::WideW
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] n_i,
  input  logic [W-1:0] d_i,
  output logic         done_o,
  output logic [W-1:0] q_o
);
  localparam int unsigned CntW = $clog2(W);

  logic [W-1:0]    n_q, d_q, r_q;
  logic [W:0]      r_sh;
  logic            ge;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;

  assign r_sh = {r_q, n_q[W-1]};
  assign ge   = r_sh >= {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CntW'(W - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(W - 1)) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q <= n_i;
      d_q <= d_i;
      r_q <= '0;
    end else if (busy_q) begin
      r_q <= ge ? W'(r_sh - {1'b0, d_q}) : r_sh[W-1:0];
      n_q <= {n_q[W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign q_o    = n_q;

endmodule

/* sv/iat_dp.sv */
// Datapath: sample memory, lag sweep accumulators, result registers and square root.
module iat_dp #(
  parameter int unsigned MAX_SAMPLES = iat_pkg::MaxSamplesDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  iat_pkg::cmd_t                    cmd_i,
  input  logic signed [iat_pkg::DataW-1:0] sample_i,
  input  logic                             out_ready_i,
  output iat_pkg::sts_t                    sts_o,
  output logic                             out_valid_o,
  output logic signed [iat_pkg::DataW-1:0] mean_o,
  output logic        [iat_pkg::DataW-1:0] error_o,
  output logic        [iat_pkg::DataW-1:0] tau_twice_o,
  output logic        [iat_pkg::StatW-1:0] status_o
);
  localparam int unsigned DW  = iat_pkg::DataW;
  localparam int unsigned XW  = iat_pkg::WideW;
  localparam int unsigned GW  = iat_pkg::GW;
  localparam int unsigned BW  = iat_pkg::MulBW;
  localparam int unsigned AW  = $clog2(MAX_SAMPLES);
  localparam int unsigned CW  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SW  = DW + CW;
  localparam int unsigned PW  = 2 * DW + CW;

  // Sample memory with two registered read ports.
  logic signed [DW-1:0] mem_q [MAX_SAMPLES];
  logic signed [DW-1:0] rda_q, rdb_q;
  logic signed [2*DW-1:0] prod_q;

  logic [CW-1:0] count_q, k_q, i_q, m;
  logic          rd_v_q, pv_q, issue;
  logic [SW-1:0] s0_q, sk_q, s0_mag, sk_mag;
  logic [PW-1:0] p_q, p_mag;

  logic [XW-1:0] num_q, d_q, w_q, w50;
  logic [GW-1:0] g0_q, g_q;
  logic [DW-1:0] mean_q, err_q, tt_q;
  iat_pkg::stat_e stat_q;

  logic run_q, start, op_done;
  logic mul_start, mul_done, div_start, div_done;
  logic [XW-1:0] mul_a, mul_p, div_n, div_d, div_q;
  logic [BW-1:0] mul_b;

  logic [GW-1:0] sq_n_q, sq_res_q, sq_bit_q, sq_trial;
  logic          sq_run_q, sq_done_q, sq_start;

  logic          ov_q;
  logic [DW-1:0] o_mean_q, o_err_q, o_tt_q;
  iat_pkg::stat_e o_stat_q;

  assign m      = count_q - k_q;
  assign issue  = cmd_i.sweep_run && (i_q != m);
  assign s0_mag = s0_q[SW-1] ? (~s0_q + 1'b1) : s0_q;
  assign sk_mag = sk_q[SW-1] ? (~sk_q + 1'b1) : sk_q;
  assign p_mag  = p_q[PW-1]  ? (~p_q + 1'b1)  : p_q;
  assign w50    = {w_q[XW-6:0], 5'd0} + {w_q[XW-5:0], 4'd0} + {w_q[XW-2:0], 1'b0};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (count_q < CW'(MAX_SAMPLES))) mem_q[count_q[AW-1:0]] <= sample_i;
    rda_q <= mem_q[i_q[AW-1:0]];
    rdb_q <= mem_q[AW'(i_q + k_q)];
  end

  // Operation launch: one unit runs at a time.
  assign start     = (cmd_i.op != iat_pkg::OpNone) && !run_q;
  assign mul_start = start && (cmd_i.op == iat_pkg::OpMp || cmd_i.op == iat_pkg::OpSs ||
                               cmd_i.op == iat_pkg::OpMm || cmd_i.op == iat_pkg::OpNg);
  assign div_start = start && (cmd_i.op == iat_pkg::OpMean || cmd_i.op == iat_pkg::OpG ||
                               cmd_i.op == iat_pkg::OpTt || cmd_i.op == iat_pkg::OpErr);
  assign sq_start  = start && (cmd_i.op == iat_pkg::OpSqrt);
  assign op_done   = run_q && (mul_done || div_done || sq_done_q);

  always_comb begin
    unique case (cmd_i.op)
      iat_pkg::OpMp: begin
        mul_a = XW'(p_mag);
        mul_b = BW'(m);
      end
      iat_pkg::OpSs: begin
        mul_a = XW'(s0_mag);
        mul_b = BW'(sk_mag);
      end
      iat_pkg::OpMm: begin
        mul_a = XW'(m);
        mul_b = BW'(m);
      end
      default: begin
        mul_a = XW'(g0_q);
        mul_b = BW'(count_q);
      end
    endcase
    unique case (cmd_i.op)
      iat_pkg::OpMean: begin
        div_n = XW'(s0_mag) + (s0_q[SW-1] ? XW'(count_q - 1'b1) : '0);
        div_d = XW'(count_q);
      end
      iat_pkg::OpG: begin
        div_n = num_q;
        div_d = d_q;
      end
      iat_pkg::OpTt: begin
        div_n = {w_q[XW-17:0], 16'd0};
        div_d = XW'(g0_q);
      end
      default: begin
        div_n = w_q;
        div_d = XW'(count_q - 1'b1);
      end
    endcase
  end

  iat_mul #(.AW(XW), .BW(BW)) u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .p_o(mul_p)
  );

  iat_div #(.W(XW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .n_i(div_n), .d_i(div_d),
    .done_o(div_done), .q_o(div_q)
  );

  assign sq_trial = sq_res_q + sq_bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      k_q       <= '0;
      i_q       <= '0;
      rd_v_q    <= 1'b0;
      pv_q      <= 1'b0;
      run_q     <= 1'b0;
      sq_run_q  <= 1'b0;
      sq_done_q <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      if (cmd_i.publish) begin
        count_q <= '0;
      end else if (cmd_i.load && (count_q < CW'(MAX_SAMPLES))) begin
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.eval_start) begin
        k_q <= '0;
      end else if (cmd_i.lag_upd) begin
        k_q <= k_q + 1'b1;
      end
      if (cmd_i.sweep_clr) begin
        i_q    <= '0;
        rd_v_q <= 1'b0;
        pv_q   <= 1'b0;
      end else begin
        rd_v_q <= issue;
        pv_q   <= rd_v_q;
        if (issue) i_q <= i_q + 1'b1;
      end
      if (start) begin
        run_q <= 1'b1;
      end else if (op_done) begin
        run_q <= 1'b0;
      end
      sq_done_q <= sq_run_q && sq_bit_q[0];
      if (sq_start) begin
        sq_run_q <= 1'b1;
      end else if (sq_run_q && sq_bit_q[0]) begin
        sq_run_q <= 1'b0;
      end
      if (cmd_i.publish) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep_clr) begin
      s0_q <= '0;
      sk_q <= '0;
      p_q  <= '0;
    end else begin
      if (rd_v_q) begin
        prod_q <= rda_q * rdb_q;
        s0_q   <= s0_q + {{CW{rda_q[DW-1]}}, rda_q};
        sk_q   <= sk_q + {{CW{rdb_q[DW-1]}}, rdb_q};
      end
      if (pv_q) p_q <= p_q + {{CW{prod_q[2*DW-1]}}, prod_q};
    end

    if (sq_start) begin
      sq_n_q   <= div_q[GW-1:0];
      sq_res_q <= '0;
      sq_bit_q <= GW'(1) << (GW - 2);
    end else if (sq_run_q) begin
      if (sq_n_q >= sq_trial) begin
        sq_n_q   <= sq_n_q - sq_trial;
        sq_res_q <= {1'b0, sq_res_q[GW-1:1]} + sq_bit_q;
      end else begin
        sq_res_q <= {1'b0, sq_res_q[GW-1:1]};
      end
      sq_bit_q <= {2'b00, sq_bit_q[GW-1:2]};
    end

    if (cmd_i.eval_start) begin
      stat_q <= iat_pkg::StatOk;
      err_q  <= '0;
      tt_q   <= '0;
    end
    if (cmd_i.stat_we) stat_q <= cmd_i.stat;

    if (cmd_i.lag_upd) begin
      if (k_q == '0) begin
        g0_q <= g_q;
        w_q  <= XW'(g_q);
      end else begin
        w_q <= w_q + XW'({g_q, 1'b0});
      end
    end

    if (op_done) begin
      unique case (cmd_i.op)
        iat_pkg::OpMean: mean_q <= s0_q[SW-1] ? (~div_q[DW-1:0] + 1'b1) : div_q[DW-1:0];
        iat_pkg::OpMp:   num_q  <= p_q[PW-1] ? (~mul_p + 1'b1) : mul_p;
        iat_pkg::OpSs:   num_q  <= (s0_q[SW-1] ^ sk_q[SW-1]) ? (num_q + mul_p) : (num_q - mul_p);
        iat_pkg::OpMm:   d_q    <= mul_p;
        iat_pkg::OpG:    g_q    <= div_q[GW-1:0];
        iat_pkg::OpTt:   tt_q   <= (|div_q[XW-1:DW]) ? '1 : div_q[DW-1:0];
        iat_pkg::OpNg: begin
          d_q   <= mul_p;
          num_q <= w50;
        end
        iat_pkg::OpErr:  if (|div_q[XW-1:GW]) err_q <= '1;
        iat_pkg::OpSqrt: err_q <= sq_res_q[DW-1:0];
        default: ;
      endcase
    end

    if (cmd_i.publish) begin
      o_mean_q <= mean_q;
      o_err_q  <= err_q;
      o_tt_q   <= tt_q;
      o_stat_q <= stat_q;
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.op_done    = op_done;
    sts_o.sweep_done = cmd_i.sweep_run && (i_q == m) && !rd_v_q && !pv_q;
    sts_o.k_zero     = (k_q == '0);
    sts_o.n_lt2      = (count_q < CW'(2));
    sts_o.neg        = num_q[XW-1];
    sts_o.g0_zero    = (g0_q == '0);
    sts_o.k_end      = (k_q == count_q);
    sts_o.ng_lt      = (d_q < num_q);
    sts_o.q_hi_nz    = |div_q[XW-1:GW];
    sts_o.out_busy   = ov_q && !out_ready_i;
  end

  assign out_valid_o = ov_q;
  assign mean_o      = o_mean_q;
  assign error_o     = o_err_q;
  assign tau_twice_o = o_tt_q;
  assign status_o    = o_stat_q;

  a_pub_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.publish |-> (!ov_q || out_ready_i))
    else $error("result published over a beat not yet taken");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.publish && stat_q == iat_pkg::StatDegen) |-> (err_q == '0 && tt_q == '0))
    else $error("degenerate result carries nonzero error or tau");

  a_short_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.publish && stat_q == iat_pkg::StatShort) |-> (err_q == '0))
    else $error("short-series result carries nonzero error");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_SAMPLES))
    else $error("sample count beyond memory depth");

endmodule

/* sv/iat_ctrl.sv */
// Controller: sequences loading, the per-lag sweep and the final arithmetic.
module iat_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_acc_i,
  input  logic          last_i,
  input  iat_pkg::sts_t sts_i,
  output iat_pkg::cmd_t cmd_o,
  output logic          in_ready_o
);
  typedef enum logic [16:0] {
    SIdle  = 17'h00001,
    SInit  = 17'h00002,
    SSweep = 17'h00004,
    SMean  = 17'h00008,
    SMp    = 17'h00010,
    SSs    = 17'h00020,
    SChk   = 17'h00040,
    SMm    = 17'h00080,
    SG     = 17'h00100,
    SUpd   = 17'h00200,
    STest  = 17'h00400,
    STt    = 17'h00800,
    SNg    = 17'h01000,
    SCmp   = 17'h02000,
    SErr   = 17'h04000,
    SSqrt  = 17'h08000,
    SFin   = 17'h10000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.op   = iat_pkg::OpNone;
    cmd_o.stat = iat_pkg::StatOk;
    in_ready_o = 1'b0;
    unique case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_acc_i) begin
          cmd_o.load = 1'b1;
          if (last_i) begin
            cmd_o.eval_start = 1'b1;
            state_d = SInit;
          end
        end
      end
      SInit: begin
        cmd_o.sweep_clr = 1'b1;
        state_d = SSweep;
      end
      SSweep: begin
        cmd_o.sweep_run = 1'b1;
        if (sts_i.sweep_done) state_d = sts_i.k_zero ? SMean : SMp;
      end
      SMean: begin
        cmd_o.op = iat_pkg::OpMean;
        if (sts_i.op_done) begin
          if (sts_i.n_lt2) begin
            cmd_o.stat_we = 1'b1;
            cmd_o.stat    = iat_pkg::StatDegen;
            state_d = SFin;
          end else begin
            state_d = SMp;
          end
        end
      end
      SMp: begin
        cmd_o.op = iat_pkg::OpMp;
        if (sts_i.op_done) state_d = SSs;
      end
      SSs: begin
        cmd_o.op = iat_pkg::OpSs;
        if (sts_i.op_done) state_d = SChk;
      end
      SChk: begin
        state_d = sts_i.neg ? STt : SMm;
      end
      SMm: begin
        cmd_o.op = iat_pkg::OpMm;
        if (sts_i.op_done) state_d = SG;
      end
      SG: begin
        cmd_o.op = iat_pkg::OpG;
        if (sts_i.op_done) state_d = SUpd;
      end
      SUpd: begin
        cmd_o.lag_upd = 1'b1;
        state_d = STest;
      end
      STest: begin
        priority if (sts_i.g0_zero) begin
          cmd_o.stat_we = 1'b1;
          cmd_o.stat    = iat_pkg::StatDegen;
          state_d = SFin;
        end else if (sts_i.k_end) begin
          state_d = STt;
        end else begin
          state_d = SInit;
        end
      end
      STt: begin
        cmd_o.op = iat_pkg::OpTt;
        if (sts_i.op_done) state_d = SNg;
      end
      SNg: begin
        cmd_o.op = iat_pkg::OpNg;
        if (sts_i.op_done) state_d = SCmp;
      end
      SCmp: begin
        if (sts_i.ng_lt) begin
          cmd_o.stat_we = 1'b1;
          cmd_o.stat    = iat_pkg::StatShort;
          state_d = SFin;
        end else begin
          state_d = SErr;
        end
      end
      SErr: begin
        cmd_o.op = iat_pkg::OpErr;
        if (sts_i.op_done) state_d = sts_i.q_hi_nz ? SFin : SSqrt;
      end
      SSqrt: begin
        cmd_o.op = iat_pkg::OpSqrt;
        if (sts_i.op_done) state_d = SFin;
      end
      SFin: begin
        if (!sts_i.out_busy) begin
          cmd_o.publish = 1'b1;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

endmodule

/* test/tb_integrated_autocorrelation_time_core.sv */
// Testbench for the integrated autocorrelation time core with its own series predictor.
`timescale 1ns / 100ps

module tb_integrated_autocorrelation_time_core;

  localparam int unsigned MaxSamples = iat_pkg::MaxSamplesDefault;
  localparam int unsigned DW         = iat_pkg::DataW;

  // One expected result beat of the core.
  typedef struct {
    logic [DW-1:0]  mean;
    logic [DW-1:0]  error;
    logic [DW-1:0]  tau_twice;
    iat_pkg::stat_e status;
  } estimate_t;

  logic clk_i;
  logic rst_ni;

  iat_in_if  in_if ();
  iat_out_if res_if ();

  integrated_autocorrelation_time_core #(
    .MAX_SAMPLES(MaxSamples)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .res_o (res_if)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Predictor state: the stored series and how many samples it holds.
  logic signed [DW-1:0] series_mem [MaxSamples];
  int unsigned          series_len;
  estimate_t            pending_estimates[$];

  int unsigned fail_cnt;
  int unsigned beats_sent;
  int unsigned series_done;
  int unsigned burst_left;
  int unsigned n_ok, n_short, n_degen;

  // Floor of the square root of a 64-bit value, bit by bit.
  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] probe;
    root  = '0;
    probe = 64'h4000_0000_0000_0000;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v    = v - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // Autocovariance at lag k in units of 2^-32, using the means of the leading and
  // trailing sub-series. A negative lag is flagged and returns zero.
  function automatic logic [63:0] lag_autocov(int unsigned n, int unsigned k,
                                              output logic is_neg);
    logic signed [127:0] m, a, b, s0, sk, prod_sum, num;
    logic        [127:0] quot;
    m        = 128'(n - k);
    s0       = '0;
    sk       = '0;
    prod_sum = '0;
    for (int unsigned i = 0; i < n - k; i++) begin
      a        = 128'(series_mem[i]);
      b        = 128'(series_mem[i + k]);
      s0       = s0 + a;
      sk       = sk + b;
      prod_sum = prod_sum + a * b;
    end
    num = m * prod_sum - s0 * sk;
    if (num < 0) begin
      is_neg = 1'b1;
      return '0;
    end
    is_neg = 1'b0;
    quot   = num / (m * m);
    return quot[63:0];
  endfunction

  // Evaluates the stored series of length n the way the core is specified to.
  function automatic estimate_t estimate_series(int unsigned n);
    estimate_t           est;
    logic signed [63:0]  total, avg;
    logic        [63:0]  g0, g;
    logic        [127:0] wsum, quot;
    logic                is_neg;
    total = '0;
    for (int unsigned i = 0; i < n; i++) total = total + 64'(series_mem[i]);
    // Mean rounds toward minus infinity.
    if (total >= 0) avg = total / $signed(64'(n));
    else avg = -$signed((64'(-total) + 64'(n) - 64'd1) / 64'(n));
    est.mean      = avg[31:0];
    est.error     = '0;
    est.tau_twice = '0;
    est.status    = iat_pkg::StatOk;
    g0 = (n >= 2) ? lag_autocov(n, 0, is_neg) : 64'd0;
    if (n < 2 || g0 == 0) begin
      est.status = iat_pkg::StatDegen;
      return est;
    end
    wsum = 128'(g0);
    for (int unsigned k = 1; k < n; k++) begin
      g = lag_autocov(n, k, is_neg);
      if (is_neg) break;
      wsum = wsum + (128'(g) << 1);
    end
    quot          = (wsum << 16) / 128'(g0);
    est.tau_twice = (quot > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
    if ((128'(n) * 128'(g0)) < (wsum * 128'd50)) begin
      est.status = iat_pkg::StatShort;
    end else begin
      quot = wsum / 128'(n - 1);
      if (quot[127:64] != 0) begin
        est.error = 32'hFFFF_FFFF;
      end else begin
        g         = floor_sqrt(quot[63:0]);
        est.error = (g > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : g[31:0];
      end
    end
    return est;
  endfunction

  // Track an accepted sample beat; a beat past a full store is dropped.
  task automatic record_sample(logic [DW-1:0] smp, logic lst);
    if (series_len < MaxSamples) begin
      series_mem[series_len] = smp;
      series_len++;
    end
    if (lst) begin
      pending_estimates.push_back(estimate_series(series_len));
      series_len = 0;
      series_done++;
    end
  endtask

  // Sends one sample beat. The sender runs in bursts of random length and, at two in three
  // burst starts, drops valid for a random gap before the burst.
  task automatic send_sample(logic [DW-1:0] smp, logic lst);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_if.valid  <= 1'b1;
    in_if.sample <= smp;
    in_if.last   <= lst;
    do @(posedge clk_i); while (!in_if.ready);
    record_sample(smp, lst);
    beats_sent++;
  endtask

  task automatic idle_input();
    in_if.valid <= 1'b0;
  endtask

  // Random sample drawn from a few shapes so that all bits and small values show up.
  function automatic logic [DW-1:0] rand_sample(int unsigned shape);
    case (shape)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 8191)) - 4096);
      2: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return ($urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  // A whole series of the given length; the final beat carries last.
  task automatic send_noise_series(int unsigned len, int unsigned shape);
    for (int unsigned i = 0; i < len; i++) send_sample(rand_sample(shape), i == len - 1);
  endtask

  task automatic send_ramp_series(int unsigned len, logic signed [DW-1:0] step);
    for (int unsigned i = 0; i < len; i++) send_sample(32'(step * $signed(i)), i == len - 1);
  endtask

  task automatic send_const_series(int unsigned len, logic [DW-1:0] val);
    for (int unsigned i = 0; i < len; i++) send_sample(val, i == len - 1);
  endtask

  // Degenerate series: two single-sample series, two equal samples and a flat series.
  task automatic test_degenerate();
    send_sample(32'h0001_0000, 1'b1);
    send_sample(32'h8000_0000, 1'b1);
    send_const_series(2, 32'hFFFF_FFFF);
    send_const_series(7, 32'h0003_8000);
  endtask

  // Extreme samples: alternating full-scale values and two-sample extremes.
  task automatic test_extremes();
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b1);
    for (int unsigned i = 0; i < 6; i++)
      send_sample(i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF, i == 5);
  endtask

  // A ramp is strongly correlated, so 100 tau exceeds the sample count.
  task automatic test_not_enough_samples();
    send_ramp_series(12, 32'sh0001_0000);
  endtask

  // Long white noise gives a small tau and an ok status with an error estimate.
  task automatic test_ok_status();
    send_noise_series(160, 1);
    send_noise_series(120, 0);
  endtask

  // Random series, mostly short so that the quadratic evaluation stays quick.
  task automatic test_random_series();
    int unsigned len, kind;
    while (beats_sent < 1350) begin
      len  = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 160) : $urandom_range(1, 30);
      kind = $urandom_range(0, 9);
      case (kind)
        0: send_ramp_series(len, 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17)));
        1: send_const_series(len, $urandom());
        default: send_noise_series(len, $urandom_range(0, 3));
      endcase
    end
  endtask

  // Result side: the receiver stalls in its own pattern, alternating stretches of
  // always-ready with stretches of random back-pressure.
  int unsigned rx_cycle;

  always @(posedge clk_i or negedge rst_ni) begin
    estimate_t exp_est;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      rx_cycle     <= 0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (res_if.valid && res_if.ready) begin
        if (pending_estimates.size() == 0) begin
          $error("result beat with no estimate pending");
          fail_cnt++;
        end else begin
          exp_est = pending_estimates.pop_front();
          if (res_if.mean !== exp_est.mean) begin
            $error("mean: expected %0h, got %0h", exp_est.mean, res_if.mean);
            fail_cnt++;
          end
          if (res_if.error !== exp_est.error) begin
            $error("error: expected %0h, got %0h", exp_est.error, res_if.error);
            fail_cnt++;
          end
          if (res_if.tau_twice !== exp_est.tau_twice) begin
            $error("tau_twice: expected %0h, got %0h", exp_est.tau_twice, res_if.tau_twice);
            fail_cnt++;
          end
          if (res_if.status !== exp_est.status) begin
            $error("status: expected %0d, got %0d", exp_est.status, res_if.status);
            fail_cnt++;
          end
          case (exp_est.status)
            iat_pkg::StatOk:    n_ok++;
            iat_pkg::StatShort: n_short++;
            default:            n_degen++;
          endcase
        end
      end
      if (rx_cycle[9:8] == 2'd0) res_if.ready <= 1'b1;
      else if (rx_cycle[9:8] == 2'd1) res_if.ready <= ($urandom_range(0, 3) != 0);
      else res_if.ready <= ($urandom_range(0, 1) == 0);
    end
  end

  // Main sequence. Every input is known from time zero; reset is applied once.
  initial begin
    fail_cnt     = 0;
    beats_sent   = 0;
    series_done  = 0;
    series_len   = 0;
    burst_left   = 0;
    n_ok         = 0;
    n_short      = 0;
    n_degen      = 0;
    in_if.valid  = 1'b0;
    in_if.sample = '0;
    in_if.last   = 1'b0;
    rst_ni       = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_degenerate();
    test_extremes();
    test_not_enough_samples();
    test_ok_status();
    test_random_series();
    idle_input();

    // Drain, then allow a margin for any stray beat.
    while (pending_estimates.size() != 0) @(posedge clk_i);
    repeat (2000) @(posedge clk_i);

    $display("Sent %0d sample beats in %0d series of many shapes and lengths.",
             beats_sent, series_done);
    $display("Results checked: %0d ok, %0d not enough samples, %0d degenerate.",
             n_ok, n_short, n_degen);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #40_000_000;
    $display("Timeout with %0d estimates still pending.", pending_estimates.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
